// ===== sv/htp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htp_pkg: shared definitions for the triangular probe hash table
// Sizes, operation and status codes, sequencer states, probe result bundle
// and the small helper functions for capacity and load.
// ----------------------------------------------------------------------------
package htp_pkg;

   localparam int TableDepth  = 64;
   localparam int SlotBits    = $clog2(TableDepth);
   localparam int KeyBits     = 16;
   localparam int ValueBits   = 16;
   localparam int HashBits    = 32;
   localparam int CountBits   = 7;
   localparam int CountMax    = 127;
   localparam int CapLogBits  = 3;
   localparam int CapLogReset = 4;
   localparam int CapLogMin   = 1;
   localparam int CapLogMax   = 6;
   localparam int CsrAddrBits = 3;
   localparam int CsrDataBits = 32;
   localparam int StoreBits   = KeyBits + ValueBits;
   localparam int LoadBits    = CountBits + 4;

   // register index taken from the word address bit
   localparam logic CsrCapacityLog2 = 1'b0;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_PLACE  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_OCCUPIED  = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_PROBE
   } fsm_state_type;

   typedef struct packed {
      logic                empty;
      logic                match;
      logic [SlotBits-1:0] next_slot;
   } probe_result_type;

   // number of slots in use: clamp the log to its legal range and to the store
   function automatic logic [SlotBits:0] capacity_size(input logic [CapLogBits-1:0] cap_log2);
      logic [CapLogBits-1:0] eff;
      eff = cap_log2;
      if (eff < CapLogBits'(CapLogMin)) begin
         eff = CapLogBits'(CapLogMin);
      end
      if (eff > CapLogBits'(CapLogMax)) begin
         eff = CapLogBits'(CapLogMax);
      end
      if (eff > CapLogBits'(SlotBits)) begin
         eff = CapLogBits'(SlotBits);
      end
      return (SlotBits + 1)'(1) << eff;
   endfunction

   function automatic logic [SlotBits-1:0] capacity_mask(input logic [CapLogBits-1:0] cap_log2);
      logic [SlotBits:0] cap;
      cap = capacity_size(cap_log2);
      return SlotBits'(cap - (SlotBits + 1)'(1));
   endfunction

   // count * 10 > capacity * 7
   function automatic logic load_over(input logic [CountBits-1:0]  count,
                                      input logic [CapLogBits-1:0] cap_log2);
      logic [LoadBits-1:0] lhs;
      logic [LoadBits-1:0] rhs;
      lhs = LoadBits'(count) * LoadBits'(10);
      rhs = LoadBits'(capacity_size(cap_log2)) * LoadBits'(7);
      return lhs > rhs;
   endfunction

endpackage

// ===== sv/hash_table_triangular_probe_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_table_triangular_probe_unit: open-addressing table, triangular probing
// Lookup, insert and place on a slot store of key/value pairs with valid
// bits, an entry counter and a load flag above 70 percent.
// ----------------------------------------------------------------------------
// Sequence: place and unused codes answer straight from idle; lookup and insert
//   probe P slots, P from 1 up to the capacity (at most 64), before answering.
// Throughput: one request at a time; busy stays high through the probe walk,
//   which reads one slot a cycle from the single read port of the store.
// Reset: valid bits, entry count and sequencer clear at once, capacity_log2
//   returns to 4; no clearing pass. Results show one cycle; no receiver stall.
// ----------------------------------------------------------------------------
module hash_table_triangular_probe_unit
   import htp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   // request channel
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_operation,
   input  logic [KeyBits-1:0]     req_key_id,
   input  logic [HashBits-1:0]    req_key_hash,
   input  logic [ValueBits-1:0]   req_entry_value,
   input  logic [SlotBits-1:0]    req_slot_index,

   // result channel
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_status,
   output logic [SlotBits-1:0]    rsp_found_slot,
   output logic [ValueBits-1:0]   rsp_found_value,
   output logic                   rsp_load_exceeded,

   // configuration port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CsrAddrBits-1:0] paddr,
   input  logic [CsrDataBits-1:0] pwdata,
   output logic [CsrDataBits-1:0] prdata,
   output logic                   pready
);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   fsm_state_type          state_ff, state_in;
   logic [CapLogBits-1:0]  cap_log2_ff;
   logic [TableDepth-1:0]  valid_ff;
   logic [CountBits-1:0]   count_ff, count_in;
   logic [KeyBits-1:0]     key_ff, key_in;
   logic [ValueBits-1:0]   value_ff, value_in;
   logic                   is_lookup_ff, is_lookup_in;
   logic [SlotBits-1:0]    slot_ff, slot_in;
   logic [SlotBits-1:0]    step_ff, step_in;
   logic [SlotBits-1:0]    probe_cnt_ff, probe_cnt_in;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [SlotBits-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [ValueBits-1:0]   rsp_value_ff, rsp_value_in;
   logic                   rsp_load_ff, rsp_load_in;

   // ------------------------------------------------------------------
   // Store and probe unit wiring
   // ------------------------------------------------------------------
   logic                   ram_we;
   logic [SlotBits-1:0]    ram_wr_addr;
   logic [StoreBits-1:0]   ram_wr_data;
   logic [SlotBits-1:0]    ram_rd_addr;
   logic [StoreBits-1:0]   ram_rd_data;
   logic                   set_valid;
   logic                   count_inc;
   logic [SlotBits-1:0]    mask;
   logic [SlotBits-1:0]    place_slot;
   logic                   csr_write;
   probe_result_type       probe;

   assign mask       = capacity_mask(cap_log2_ff);
   assign place_slot = req_slot_index & mask;

   // key in the upper half, value in the lower half
   htp_ram #(
      .DATA_WIDTH (StoreBits),
      .DEPTH      (TableDepth)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Read data always belongs to slot_ff while probing.
   htp_probe_step u_probe (
      .slot_valid (valid_ff[slot_ff]),
      .is_lookup  (is_lookup_ff),
      .stored_key (ram_rd_data[StoreBits-1:ValueBits]),
      .search_key (key_ff),
      .slot       (slot_ff),
      .step       (step_ff),
      .mask       (mask),
      .result     (probe)
   );

   // ------------------------------------------------------------------
   // Configuration port: zero wait states, one register
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      prdata = '0;
      if (paddr[2] == CsrCapacityLog2) begin
         prdata = CsrDataBits'(cap_log2_ff);
      end
   end

   // ------------------------------------------------------------------
   // Sequencer: next state, store writes and result
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      is_lookup_in  = is_lookup_ff;
      slot_in       = slot_ff;
      step_in       = step_ff;
      probe_cnt_in  = probe_cnt_ff;

      ram_rd_addr   = slot_ff;
      ram_we        = 1'b0;
      ram_wr_addr   = slot_ff;
      ram_wr_data   = {key_ff, value_ff};
      set_valid     = 1'b0;
      count_inc     = 1'b0;

      rsp_strobe_in = 1'b0;
      rsp_status_in = STATUS_NOT_FOUND;
      rsp_slot_in   = '0;
      rsp_value_in  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (op_type'(req_operation))
                  OP_LOOKUP, OP_INSERT: begin
                     // latch the request and issue the read of the home slot
                     key_in       = req_key_id;
                     value_in     = req_entry_value;
                     is_lookup_in = (op_type'(req_operation) == OP_LOOKUP);
                     slot_in      = req_key_hash[SlotBits-1:0] & mask;
                     step_in      = SlotBits'(1);
                     probe_cnt_in = '0;
                     ram_rd_addr  = req_key_hash[SlotBits-1:0] & mask;
                     state_in     = S_PROBE;
                  end
                  OP_PLACE: begin
                     // place finishes at once: the valid bits answer the check
                     rsp_strobe_in = 1'b1;
                     rsp_slot_in   = place_slot;
                     if (valid_ff[place_slot]) begin
                        rsp_status_in = STATUS_OCCUPIED;
                     end else begin
                        rsp_status_in = STATUS_OK;
                        ram_we        = 1'b1;
                        ram_wr_addr   = place_slot;
                        ram_wr_data   = {req_key_id, req_entry_value};
                        set_valid     = 1'b1;
                        count_inc     = 1'b1;
                     end
                  end
                  default: begin
                     // unused code: no state change
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_NOT_FOUND;
                  end
               endcase
            end
         end

         S_PROBE: begin
            priority if (probe.empty) begin
               // first free slot: insert takes it, lookup reports it
               rsp_strobe_in = 1'b1;
               rsp_slot_in   = slot_ff;
               state_in      = S_IDLE;
               if (is_lookup_ff) begin
                  rsp_status_in = STATUS_NOT_FOUND;
               end else begin
                  rsp_status_in = STATUS_OK;
                  ram_we        = 1'b1;
                  set_valid     = 1'b1;
                  count_inc     = 1'b1;
               end
            end else if (probe.match) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_slot_in   = slot_ff;
               rsp_value_in  = ram_rd_data[ValueBits-1:0];
               state_in      = S_IDLE;
            end else if (probe_cnt_ff == mask) begin
               // every slot in use visited once: table full
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_FULL;
               state_in      = S_IDLE;
            end else begin
               // advance by the growing step and read the next slot
               slot_in      = probe.next_slot;
               step_in      = step_ff + SlotBits'(1);
               probe_cnt_in = probe_cnt_ff + SlotBits'(1);
               ram_rd_addr  = probe.next_slot;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // saturate the entry count
      count_in = count_ff;
      if (count_inc && (count_ff != CountBits'(CountMax))) begin
         count_in = count_ff + CountBits'(1);
      end

      // load flag taken after the operation
      rsp_load_in = load_over(count_in, cap_log2_ff);
   end

   // ------------------------------------------------------------------
   // Control state
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cap_log2_ff   <= CapLogBits'(CapLogReset);
         valid_ff      <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (set_valid) begin
            valid_ff[ram_wr_addr] <= 1'b1;
         end
         if (csr_write && (paddr[2] == CsrCapacityLog2)) begin
            cap_log2_ff <= pwdata[CapLogBits-1:0];
         end
      end
   end

   // ------------------------------------------------------------------
   // Payload: request copy, probe position and result fields
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      value_ff      <= value_in;
      is_lookup_ff  <= is_lookup_in;
      slot_ff       <= slot_in;
      step_ff       <= step_in;
      probe_cnt_ff  <= probe_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_load_ff   <= rsp_load_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_slot    = rsp_slot_ff;
   assign rsp_found_value   = rsp_value_ff;
   assign rsp_load_exceeded = rsp_load_ff;

endmodule

// ===== sv/htp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htp_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module htp_ram #(
   parameter int DATA_WIDTH = 32,
   parameter int DEPTH      = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/htp_probe_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htp_probe_step: shared probe unit
// Classifies the slot just read (empty, or key match on a lookup) and forms the next
// triangular probe address.
// ----------------------------------------------------------------------------
module htp_probe_step
   import htp_pkg::*;
(
   input  logic                  slot_valid,
   input  logic                  is_lookup,
   input  logic [KeyBits-1:0]    stored_key,
   input  logic [KeyBits-1:0]    search_key,
   input  logic [SlotBits-1:0]   slot,
   input  logic [SlotBits-1:0]   step,
   input  logic [SlotBits-1:0]   mask,
   output probe_result_type      result
);

   always_comb begin
      result.empty     = !slot_valid;
      result.match     = slot_valid && is_lookup && (stored_key == search_key);
      // wrap at the capacity in use
      result.next_slot = (slot + step) & mask;
   end

endmodule

// ===== tb/sv/hash_table_triangular_probe_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_table_triangular_probe_unit_tb: self-checking bench for the probe table
// Drives lookup, insert and place requests plus capacity writes through the
// APB-style port, keeps a shadow copy of the slot store and entry count, and
// checks every response field against the shadow prediction.
// ----------------------------------------------------------------------------
module hash_table_triangular_probe_unit_tb;
   import htp_pkg::*;

   // byte address of the capacity register: word index times four
   localparam logic [CsrAddrBits-1:0] CapLog2Addr = {CsrCapacityLog2, 2'b00};

   typedef struct packed {
      op_type               op;
      logic [KeyBits-1:0]   key;
      logic [HashBits-1:0]  hash;
      logic [ValueBits-1:0] value;
      logic [SlotBits-1:0]  slot;
   } probe_request_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [SlotBits-1:0]  slot;
      logic [ValueBits-1:0] value;
      logic                 load;
   } probe_reply_type;

   // Shadow of the slot store and entry count; holds the replies still owed
   class table_scoreboard_type;
      logic                  used [TableDepth];
      logic [KeyBits-1:0]    keys [TableDepth];
      logic [ValueBits-1:0]  values [TableDepth];
      int unsigned           entries;
      logic [CapLogBits-1:0] cap_log2;
      probe_reply_type       pending_replies [$];
      int unsigned           mismatches;

      function new();
         foreach (used[i]) begin
            used[i]   = 1'b0;
            keys[i]   = '0;
            values[i] = '0;
         end
         entries    = 0;
         cap_log2   = CapLogBits'(CapLogReset);
         mismatches = 0;
      endfunction

      function void set_capacity(logic [CapLogBits-1:0] lg);
         cap_log2 = lg;
      endfunction

      // clamp the log to 1..6, then fit the slot count into the store
      function int unsigned slots_in_use();
         int unsigned lg;
         int unsigned cap;
         lg = cap_log2;
         if (lg < CapLogMin) lg = CapLogMin;
         if (lg > CapLogMax) lg = CapLogMax;
         cap = 1 << lg;
         while (cap > TableDepth) cap = cap >> 1;
         return cap;
      endfunction

      function void fill_slot(int unsigned s, logic [KeyBits-1:0] k,
                              logic [ValueBits-1:0] v);
         used[s]   = 1'b1;
         keys[s]   = k;
         values[s] = v;
         if (entries < CountMax) entries++;
      endfunction

      // Work out the reply to an accepted request, update the shadow store
      // and queue the reply for checking.
      function probe_reply_type predict_reply(probe_request_type r);
         probe_reply_type want;
         int unsigned     cap;
         int unsigned     mask;
         int unsigned     s;
         int unsigned     step;
         int unsigned     n;
         bit              done;
         cap         = slots_in_use();
         mask        = cap - 1;
         want.status = STATUS_NOT_FOUND;
         want.slot   = '0;
         want.value  = '0;
         done        = 1'b0;
         case (r.op)
            OP_LOOKUP, OP_INSERT: begin
               s    = r.hash & mask;
               step = 1;
               for (n = 0; n < cap && !done; n++) begin
                  if (!used[s]) begin
                     if (r.op == OP_INSERT) begin
                        fill_slot(s, r.key, r.value);
                        want.status = STATUS_OK;
                     end
                     want.slot = SlotBits'(s);
                     done      = 1'b1;
                  end else if (r.op == OP_LOOKUP && keys[s] == r.key) begin
                     want.status = STATUS_OK;
                     want.slot   = SlotBits'(s);
                     want.value  = values[s];
                     done        = 1'b1;
                  end else begin
                     s = (s + step) & mask;
                     step++;
                  end
               end
               if (!done) begin
                  want.status = STATUS_FULL;
                  want.slot   = '0;
                  want.value  = '0;
               end
            end
            OP_PLACE: begin
               s         = r.slot & mask;
               want.slot = SlotBits'(s);
               if (used[s]) begin
                  want.status = STATUS_OCCUPIED;
               end else begin
                  fill_slot(s, r.key, r.value);
                  want.status = STATUS_OK;
               end
            end
            default: ;
         endcase
         // load above 70 percent, taken after the operation
         want.load = (entries * 10 > cap * 7);
         pending_replies.push_back(want);
         return want;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_reply(probe_reply_type got);
         probe_reply_type want;
         if (pending_replies.size() == 0) begin
            $error("response with no request outstanding: status %0d slot %0d",
                   got.status, got.slot);
            mismatches++;
            return;
         end
         want = pending_replies.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("found_slot", want.slot, got.slot);
         compare_field("found_value", want.value, got.value);
         compare_field("load_exceeded", want.load, got.load);
      endfunction
   endclass

   logic                   clock;
   logic                   reset           = 1'b1;
   logic                   start           = 1'b0;
   logic                   busy;
   logic [1:0]             req_operation   = '0;
   logic [KeyBits-1:0]     req_key_id      = '0;
   logic [HashBits-1:0]    req_key_hash    = '0;
   logic [ValueBits-1:0]   req_entry_value = '0;
   logic [SlotBits-1:0]    req_slot_index  = '0;
   logic                   rsp_strobe;
   logic [1:0]             rsp_status;
   logic [SlotBits-1:0]    rsp_found_slot;
   logic [ValueBits-1:0]   rsp_found_value;
   logic                   rsp_load_exceeded;
   logic                   psel            = 1'b0;
   logic                   penable         = 1'b0;
   logic                   pwrite          = 1'b0;
   logic [CsrAddrBits-1:0] paddr           = '0;
   logic [CsrDataBits-1:0] pwdata          = '0;
   logic [CsrDataBits-1:0] prdata;
   logic                   pready;

   table_scoreboard_type   sb;
   probe_request_type      stored_requests [$];   // inserts and places that landed

   hash_table_triangular_probe_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_key_id        (req_key_id),
      .req_key_hash      (req_key_hash),
      .req_entry_value   (req_entry_value),
      .req_slot_index    (req_slot_index),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_found_slot    (rsp_found_slot),
      .rsp_found_value   (rsp_found_value),
      .rsp_load_exceeded (rsp_load_exceeded),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

   // Sample each strobed response at the edge that ends its cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         sb.check_reply({rsp_status, rsp_found_slot, rsp_found_value, rsp_load_exceeded});
      end
   end

   function automatic probe_request_type make_request(op_type op,
                                                      logic [KeyBits-1:0] key,
                                                      logic [HashBits-1:0] hash,
                                                      logic [ValueBits-1:0] value,
                                                      logic [SlotBits-1:0] slot);
      probe_request_type r;
      r.op    = op;
      r.key   = key;
      r.hash  = hash;
      r.value = value;
      r.slot  = slot;
      return r;
   endfunction

   // Present a request and hold it until an edge sees busy low. Leave start
   // high on return so back-to-back requests need no extra assignment.
   task automatic send_request(input probe_request_type r, output probe_reply_type want);
      start           <= 1'b1;
      req_operation   <= r.op;
      req_key_id      <= r.key;
      req_key_hash    <= r.hash;
      req_entry_value <= r.value;
      req_slot_index  <= r.slot;
      do @(posedge clock); while (busy);
      want = sb.predict_reply(r);
      if (want.status == STATUS_OK && r.op != OP_LOOKUP) begin
         stored_requests.push_back(r);
      end
   endtask

   task automatic hold_off(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop start and wait until every owed response has come back
   task automatic drain_replies();
      start <= 1'b0;
      while (sb.pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Capacity write on an idle block: setup cycle, then access until pready
   task automatic write_capacity(input logic [CapLogBits-1:0] lg);
      drain_replies();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CapLog2Addr;
      pwdata  <= CsrDataBits'(lg);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_capacity(lg);
   endtask

   // Idle the sender now and then; sometimes wait for the block to empty
   task automatic pace(input int unsigned idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         hold_off($urandom_range(1, 5));
      end else if ($urandom_range(59) == 0) begin
         drain_replies();
      end
   endtask

   // Mostly well-formed traffic: lookups of stored keys with their own hash,
   // lookups followed by a place on the returned slot, plus plain inserts,
   // random places and the unused operation code as noise.
   task automatic run_random(input int unsigned count, input int unsigned idle_pct);
      probe_request_type r;
      probe_reply_type   want;
      int unsigned       pick;
      for (int unsigned i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         r    = make_request(op_type'($urandom_range(3)), KeyBits'($urandom), $urandom,
                             ValueBits'($urandom), SlotBits'($urandom));
         if (pick < 40 && stored_requests.size() > 0) begin
            r        = stored_requests[$urandom_range(stored_requests.size() - 1)];
            r.op     = OP_LOOKUP;
         end else if (pick < 62) begin
            r.op = OP_LOOKUP;
         end else if (pick < 74) begin
            r.op = OP_INSERT;
         end else if (pick < 84) begin
            r.op = OP_LOOKUP;
            send_request(r, want);
            pace(idle_pct);
            r.op    = OP_PLACE;
            r.slot  = want.slot;
            r.value = ValueBits'($urandom);
         end else if (pick < 93) begin
            r.op = OP_PLACE;
         end else if (pick < 97) begin
            r.op = OP_NONE;
         end
         send_request(r, want);
         pace(idle_pct);
      end
   endtask

   initial begin
      probe_reply_type want;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: default capacity of 16 slots
      send_request(make_request(OP_LOOKUP, 16'h0000, 32'h0000_0000, 16'h0000, 6'd0), want);
      send_request(make_request(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 6'd63), want);
      send_request(make_request(OP_INSERT, 16'h0000, 32'h0000_0000, 16'h0000, 6'd0), want);
      send_request(make_request(OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 6'd0), want);
      // collide on the last slot, wrap to slot 0, stop on the empty slot 2
      send_request(make_request(OP_LOOKUP, 16'h1234, 32'h0000_000F, 16'h0000, 6'd0), want);
      send_request(make_request(OP_PLACE, 16'h1234, 32'h0000_000F, 16'hA5A5, want.slot), want);
      send_request(make_request(OP_LOOKUP, 16'h1234, 32'h0000_000F, 16'h0000, 6'd0), want);
      // place index wraps onto an occupied slot, then onto a free one
      send_request(make_request(OP_PLACE, 16'h5A5A, 32'h0000_0000, 16'h5A5A, 6'd63), want);
      send_request(make_request(OP_PLACE, 16'h5A5A, 32'h0000_0000, 16'h5A5A, 6'd49), want);
      send_request(make_request(OP_NONE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 6'd63), want);
      // duplicate key on insert is not checked; lookup hits the first copy
      send_request(make_request(OP_INSERT, 16'h0000, 32'h0000_0010, 16'h0001, 6'd0), want);
      send_request(make_request(OP_LOOKUP, 16'h0000, 32'h0000_0010, 16'h0000, 6'd0), want);

      // Zero saturates to two slots, both occupied: full table cases
      write_capacity(3'd0);
      send_request(make_request(OP_LOOKUP, 16'h7777, 32'h0000_0001, 16'h0000, 6'd0), want);
      send_request(make_request(OP_INSERT, 16'h7777, 32'h0000_0000, 16'h1111, 6'd0), want);
      send_request(make_request(OP_PLACE, 16'h7777, 32'h0000_0000, 16'h1111, 6'd5), want);
      send_request(make_request(OP_LOOKUP, 16'h5A5A, 32'h0000_0001, 16'h0000, 6'd0), want);

      // Seven saturates to the full 64 slots
      write_capacity(3'd7);
      send_request(make_request(OP_LOOKUP, 16'hFFFF, 32'h0000_002F, 16'h0000, 6'd0), want);

      // Random traffic across several table sizes
      run_random(180, 38);
      write_capacity(3'd1);
      run_random(35, 88);
      write_capacity(3'd3);
      run_random(55, 88);
      write_capacity(3'd5);
      run_random(80, 88);
      write_capacity(3'd6);
      run_random(140, 0);

      // Wait out the last responses plus the longest probe walk
      drain_replies();
      repeat (70) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/htp_pkg.sv
sv/htp_ram.sv
sv/htp_probe_step.sv
sv/hash_table_triangular_probe_unit.sv
tb/sv/hash_table_triangular_probe_unit_tb.sv
